// ===== design/dss_pkg.sv =====
package dss_pkg;

    // Step dividend: 44100 in Q16.16
    localparam logic [31:0] STEP_DIVIDEND = 32'd2890137600;
    localparam int          FREQ_W        = 20;
    localparam logic [19:0] MAX_FREQ      = 20'd705600;

    typedef enum logic [2:0] {
        MODE_TICK,
        MODE_FREQ,
        MODE_STOP,
        MODE_START,
        MODE_LOAD
    } mode_t;

    typedef enum logic [1:0] {
        KIND_WRITE,
        KIND_SEEK,
        KIND_REJECT
    } kind_t;

    typedef enum logic [1:0] {
        CFG_BLOCK_COUNT,
        CFG_WHOLE_PRESENT,
        CFG_WHOLE_SIZE
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_TICK,
        ST_SEEK,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== design/dss_if.sv =====
interface dss_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [31:0] frequency;
    logic [15:0] block_id;
    logic [31:0] entry_offset;
    logic [31:0] entry_size;

    modport source (output valid, mode, frequency, block_id, entry_offset, entry_size,
                    input ready);
    modport sink   (input valid, mode, frequency, block_id, entry_offset, entry_size,
                    output ready);
endinterface

interface dss_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] sample_time;
    logic [31:0] seek_offset;
    logic        last;

    modport source (output valid, kind, sample_time, seek_offset, last, input ready);
    modport sink   (input valid, kind, sample_time, seek_offset, last, output ready);
endinterface

// ===== design/dss_ram.sv =====
module dss_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ===== design/dss_div.sv =====
module dss_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dss_pkg::FREQ_W-1:0] divisor,
    output dss_pkg::div_status_t       status,
    output logic [31:0]                quotient
);
    import dss_pkg::*;

    logic [31:0]       q_reg, q_next;
    logic [FREQ_W-1:0] rem_reg, rem_next;
    logic [FREQ_W-1:0] div_reg;
    logic [4:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [FREQ_W:0]   shifted;
    logic [FREQ_W:0]   diff;
    logic              ge;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, q_reg[31]};
        diff     = shifted - {1'b0, div_reg};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? diff[FREQ_W-1:0] : shifted[FREQ_W-1:0];
        q_next   = {q_reg[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= STEP_DIVIDEND;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = q_reg;
endmodule

// ===== design/dac_stream_sample_scheduler.sv =====
// DAC stream sample scheduler.
// Input channel in_ch carries one command word per handshake: tick, set frequency,
// stop, start block or load block entry. Output channel out_ch carries result words
// (DAC write, seek or rejected start), the final word of each command marked last.
// Configuration is written through cfg_we / cfg_index / cfg_data while the block is
// idle, a rule for the user that the block itself does not enforce; index 0 block
// count, 1 whole-data present, 2 whole-data size. Load, stop and ignored modes stay
// idle. A tick emits its due writes (at most MAX_WRITES_PER_TICK) from the single
// write loop, which updates stream time once per cycle while the output is not
// stalled. A start waits on the registered read of the block table memory. A
// frequency set runs the radix-2 divider producing one quotient bit per cycle.
// A single output register holds the oldest result; the next command is accepted
// while that word still waits. When the receiver stalls, generation stalls with it
// and nothing is lost. Reset clears time, stream state, step and configuration;
// the block table is undefined until loaded.
module dac_stream_sample_scheduler #(
    parameter int MAX_BLOCKS          = 256,
    parameter int MAX_WRITES_PER_TICK = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    dss_in_if.sink      in_ch,
    dss_out_if.source   out_ch
);
    import dss_pkg::*;

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int NW = $clog2(MAX_WRITES_PER_TICK + 1);
    localparam logic [16:0] MAXB = 17'(MAX_BLOCKS);
    localparam logic [NW-1:0] CAP = NW'(MAX_WRITES_PER_TICK);

    state_t state_reg, state_next;

    logic [8:0]  block_count_reg;
    logic        whole_present_reg;
    logic [31:0] whole_size_reg;

    logic [31:0] now_reg;
    logic [31:0] stream_time_reg;
    logic        active_reg;
    logic [33:0] pending_reg;
    logic [31:0] step_reg;
    logic [31:0] left_reg;
    logic [NW-1:0] n_reg;
    logic        staged_reg;
    logic [31:0] staged_time_reg;
    logic        ok_reg;
    logic        whole_reg;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [31:0] out_time_reg;
    logic [31:0] out_off_reg;
    logic        out_last_reg;

    logic        accept;
    mode_t       mode;
    logic        slot_free;
    logic [31:0] gap;
    logic        due;
    logic [31:0] st_new;
    logic [33:0] pend_new;
    logic [31:0] start_off;
    logic [31:0] start_len;
    logic        start_ok;

    logic        push;
    kind_t       push_kind;
    logic [31:0] push_time;
    logic [31:0] push_off;
    logic        push_last;
    logic        adv_write;
    logic        start_load;

    logic        ram_we;
    logic        ram_re;
    logic [63:0] ram_rdata;
    logic        div_start;
    logic [FREQ_W-1:0] div_divisor;
    div_status_t div_status;
    logic [31:0] div_quot;

    assign accept    = in_ch.valid && in_ch.ready;
    assign mode      = mode_t'(in_ch.mode);
    assign slot_free = !out_valid_reg || out_ch.ready;

    assign ram_we = accept && (mode == MODE_LOAD) && ({1'b0, in_ch.block_id} < MAXB);
    assign ram_re = accept && (mode == MODE_START);

    dss_ram #(
        .WIDTH(64),
        .DEPTH(MAX_BLOCKS),
        .AW   (AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(in_ch.block_id[AW-1:0]),
        .wdata({in_ch.entry_offset, in_ch.entry_size}),
        .re   (ram_re),
        .raddr(in_ch.block_id[AW-1:0]),
        .rdata(ram_rdata)
    );

    assign div_start   = accept && (mode == MODE_FREQ) && (in_ch.frequency != 32'd0);
    assign div_divisor = (in_ch.frequency > {12'd0, MAX_FREQ}) ? MAX_FREQ
                                                             : in_ch.frequency[FREQ_W-1:0];

    dss_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (div_divisor),
        .status  (div_status),
        .quotient(div_quot)
    );

    // Write timing
    assign gap      = now_reg - stream_time_reg;
    assign due      = active_reg && (n_reg < CAP) && ({14'd0, pending_reg[33:16]} <= gap);
    assign st_new   = stream_time_reg + {14'd0, pending_reg[33:16]};
    assign pend_new = {18'd0, pending_reg[15:0]} + {2'd0, step_reg};

    assign start_ok  = (block_count_reg == 9'd0) ? whole_present_reg
                     : (({1'b0, in_ch.block_id} < {8'd0, block_count_reg})
                        && ({1'b0, in_ch.block_id} < MAXB));
    assign start_off = whole_reg ? 32'd0 : ram_rdata[63:32];
    assign start_len = whole_reg ? whole_size_reg : ram_rdata[31:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_TICK:  state_next = ST_TICK;
                        MODE_FREQ:  state_next = div_start ? ST_DIV : ST_IDLE;
                        MODE_START: state_next = ST_SEEK;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TICK:
            begin
                if (!due && (!staged_reg || slot_free))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SEEK:
            begin
                if (slot_free)
                begin
                    state_next = (!ok_reg || start_len == 32'd0) ? ST_IDLE : ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        push       = 1'b0;
        push_kind  = KIND_WRITE;
        push_time  = now_reg;
        push_off   = 32'd0;
        push_last  = 1'b1;
        adv_write  = 1'b0;
        start_load = 1'b0;
        case (state_reg)
            ST_TICK:
            begin
                // Emit the staged write once the next one is known
                push_time = staged_time_reg;
                if (due)
                begin
                    adv_write = !staged_reg || slot_free;
                    push      = staged_reg && slot_free;
                    push_last = 1'b0;
                end
                else
                begin
                    push = staged_reg && slot_free;
                end
            end
            ST_SEEK:
            begin
                push = slot_free;
                if (!ok_reg)
                begin
                    push_kind = KIND_REJECT;
                end
                else
                begin
                    push_kind  = KIND_SEEK;
                    push_off   = start_off;
                    push_last  = (start_len == 32'd0);
                    start_load = slot_free;
                end
            end
            ST_WRITE:
            begin
                push = slot_free;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_count_reg   <= '0;
            whole_present_reg <= 1'b0;
            whole_size_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BLOCK_COUNT:   block_count_reg   <= cfg_data[8:0];
                CFG_WHOLE_PRESENT: whole_present_reg <= cfg_data[0];
                CFG_WHOLE_SIZE:    whole_size_reg    <= cfg_data;
                default:           block_count_reg   <= block_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            now_reg         <= '0;
            stream_time_reg <= '0;
            active_reg      <= 1'b0;
            pending_reg     <= '0;
            step_reg        <= '0;
            left_reg        <= '0;
            n_reg           <= '0;
            staged_reg      <= 1'b0;
            ok_reg          <= 1'b0;
            whole_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && mode == MODE_TICK)
            begin
                now_reg    <= now_reg + 32'd1;
                n_reg      <= '0;
                staged_reg <= 1'b0;
            end
            if (accept && mode == MODE_STOP)
            begin
                active_reg <= 1'b0;
            end
            if (accept && mode == MODE_START)
            begin
                ok_reg    <= start_ok;
                whole_reg <= (block_count_reg == 9'd0);
            end
            if (adv_write)
            begin
                stream_time_reg <= st_new;
                pending_reg     <= pend_new;
                left_reg        <= left_reg - 32'd1;
                active_reg      <= (left_reg != 32'd1);
                n_reg           <= n_reg + NW'(1);
                staged_reg      <= 1'b1;
            end
            if (start_load)
            begin
                stream_time_reg <= now_reg;
                pending_reg     <= {2'd0, step_reg};
                left_reg        <= (start_len == 32'd0) ? 32'd0 : start_len - 32'd1;
                active_reg      <= (start_len > 32'd1);
            end
            if (div_status.done)
            begin
                step_reg <= div_quot;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_write)
        begin
            staged_time_reg <= st_new;
        end
        if (push)
        begin
            out_kind_reg <= push_kind;
            out_time_reg <= push_time;
            out_off_reg  <= push_off;
            out_last_reg <= push_last;
        end
    end

    assign in_ch.ready        = (state_reg == ST_IDLE);
    assign out_ch.valid       = out_valid_reg;
    assign out_ch.kind        = out_kind_reg;
    assign out_ch.sample_time = out_time_reg;
    assign out_ch.seek_offset = out_off_reg;
    assign out_ch.last        = out_last_reg;
endmodule
